// File: rtl/env_sensor_compensation_macros.svh
// Assertion macros for the checker file.
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ESC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion that also covers cycles in reset.
`define ESC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// File: rtl/esc_pkg.sv
`default_nettype none

package esc_pkg;

    // Port widths
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_TEMP    = 3'd0,
        REG_CAL_PRESS_A = 3'd1,
        REG_CAL_PRESS_B = 3'd2,
        REG_CAL_MISC    = 3'd3,
        REG_CAL_HUMID   = 3'd4,
        REG_TEMP_OFFSET = 3'd5
    } cfg_reg_t;

    // Divider: 64 quotient bits, a few per stage
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = 64 / DIV_STEPS;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    // Low 64 bits of a 64 x 64 product as three 32 x 32 partial products
    typedef struct packed {
        logic [63:0] p0;
        logic [31:0] p1;
        logic [31:0] p2;
    } pp_t;

    // Results that ride alongside the divider
    typedef struct packed {
        logic [23:0] temp;
        logic [16:0] humid;
        logic        inv;
    } side_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] num;
        logic [30:0] den;
        logic        neg;
        side_t       side;
    } div_in_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] quo;
        logic        neg;
        side_t       side;
    } div_out_t;

    typedef struct packed {
        logic [30:0] rem;
        logic [63:0] nq;
    } div_state_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] mul32lo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] f;
        f = {32'b0, a} * {32'b0, b};
        return f[31:0];
    endfunction

    function automatic pp_t mk_pp(input logic [63:0] a, input logic [63:0] b);
        pp_t         r;
        logic [63:0] f1;
        logic [63:0] f2;
        r.p0 = {32'b0, a[31:0]} * {32'b0, b[31:0]};
        f1   = {32'b0, a[31:0]} * {32'b0, b[63:32]};
        f2   = {32'b0, a[63:32]} * {32'b0, b[31:0]};
        r.p1 = f1[31:0];
        r.p2 = f2[31:0];
        return r;
    endfunction

    function automatic logic [63:0] pp_sum(input pp_t x);
        logic [31:0] hi;
        hi = x.p1 + x.p2;
        return x.p0 + {hi, 32'b0};
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx16_64(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    // A few restoring steps; divisor is at most 2^30 so the remainder fits
    function automatic div_state_t div_steps(input div_state_t s, input logic [30:0] den);
        div_state_t  r;
        logic [30:0] sh;
        r = s;
        for (int i = 0; i < DIV_STEPS; i++) begin
            sh = {r.rem[29:0], r.nq[63]};
            if (sh >= den) begin
                r.rem = sh - den;
                r.nq  = {r.nq[62:0], 1'b1};
            end else begin
                r.rem = sh;
                r.nq  = {r.nq[62:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/esc_div.sv
`default_nettype none

// Pipelined unsigned 64 / 31 bit divider, DIV_STEPS quotient bits per stage
module esc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  esc_pkg::div_in_t  din,
    output esc_pkg::div_out_t dout
);
    import esc_pkg::*;

    div_state_t            st_reg   [0:DIV_STAGES-1];
    logic [30:0]           den_reg  [0:DIV_STAGES-1];
    logic                  neg_reg  [0:DIV_STAGES-1];
    side_t                 side_reg [0:DIV_STAGES-1];
    logic [DIV_STAGES-1:0] vld_reg;

    div_state_t  st_in   [0:DIV_STAGES-1];
    logic [30:0] den_in  [0:DIV_STAGES-1];
    logic        neg_in  [0:DIV_STAGES-1];
    side_t       side_in [0:DIV_STAGES-1];

    // stage inputs: first from the port, the rest from the stage before
    always_comb begin
        st_in[0].rem = '0;
        st_in[0].nq  = din.num;
        den_in[0]    = din.den;
        neg_in[0]    = din.neg;
        side_in[0]   = din.side;
        for (int g = 1; g < DIV_STAGES; g++) begin
            st_in[g]   = st_reg[g-1];
            den_in[g]  = den_reg[g-1];
            neg_in[g]  = neg_reg[g-1];
            side_in[g] = side_reg[g-1];
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], din.valid};
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < DIV_STAGES; g++) begin
                st_reg[g]   <= div_steps(st_in[g], den_in[g]);
                den_reg[g]  <= den_in[g];
                neg_reg[g]  <= neg_in[g];
                side_reg[g] <= side_in[g];
            end
        end
    end

    assign dout.valid = vld_reg[DIV_STAGES-1];
    assign dout.quo   = st_reg[DIV_STAGES-1].nq;
    assign dout.neg   = neg_reg[DIV_STAGES-1];
    assign dout.side  = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/env_sensor_compensation.sv
`default_nettype none

// Channel   Direction  Payload
// s_        in         raw temperature, pressure and humidity triple
// m_        out        temperature, pressure, humidity; tuser = pressure invalid
// cfg_      in         calibration and offset register writes
//
// One transaction accepted per cycle while m_ is not stalled; 13 front stages,
// 16 divider stages at 4 quotient bits each, 7 back stages.
// The 64-bit pressure division sets the depth of the pipe.
// Reset clears valid bits and configuration registers; no clearing pass.
// A stall on m_ freezes the whole pipe; nothing is dropped or repeated.
module env_sensor_compensation (
    input  logic                           aclk,
    input  logic                           aresetn,
    // raw_temp [19:0], raw_press [39:20], raw_humid [55:40]
    input  logic [esc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // temp_centi [23:0], press_q24_8 [55:24], humid_q7_10 [72:56], zero pad
    output logic [esc_pkg::M_TDATA_W-1:0]  m_tdata,
    // press_invalid [0]
    output logic                           m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import esc_pkg::*;

    // configuration registers
    logic [47:0] cal_temp_reg;
    logic [63:0] cal_pa_reg;
    logic [63:0] cal_pb_reg;
    logic [47:0] cal_misc_reg;
    logic [39:0] cal_hum_reg;
    logic [15:0] toff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg <= '0;
            cal_pa_reg   <= '0;
            cal_pb_reg   <= '0;
            cal_misc_reg <= '0;
            cal_hum_reg  <= '0;
            toff_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CAL_TEMP:    cal_temp_reg <= cfg_wdata[47:0];
                REG_CAL_PRESS_A: cal_pa_reg   <= cfg_wdata;
                REG_CAL_PRESS_B: cal_pb_reg   <= cfg_wdata;
                REG_CAL_MISC:    cal_misc_reg <= cfg_wdata[47:0];
                REG_CAL_HUMID:   cal_hum_reg  <= cfg_wdata[39:0];
                REG_TEMP_OFFSET: toff_reg     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // calibration words
    logic [15:0]        t1;
    logic [31:0]        t2_32, t3_32;
    logic [15:0]        p1;
    logic signed [15:0] p2, p5;
    logic [63:0]        p3_64, p4_64, p6_64, p7_64, p8_64, p9_64;
    logic [7:0]         h1, h3;
    logic [31:0]        h2_32, h4_32, h5_32, h6_32;

    assign t1    = cal_temp_reg[15:0];
    assign t2_32 = sx16_32(cal_temp_reg[31:16]);
    assign t3_32 = sx16_32(cal_temp_reg[47:32]);
    assign p1    = cal_pa_reg[15:0];
    assign p2    = cal_pa_reg[31:16];
    assign p3_64 = sx16_64(cal_pa_reg[47:32]);
    assign p4_64 = sx16_64(cal_pa_reg[63:48]);
    assign p5    = cal_pb_reg[15:0];
    assign p6_64 = sx16_64(cal_pb_reg[31:16]);
    assign p7_64 = sx16_64(cal_pb_reg[47:32]);
    assign p8_64 = sx16_64(cal_pb_reg[63:48]);
    assign p9_64 = sx16_64(cal_misc_reg[15:0]);
    assign h1    = cal_misc_reg[23:16];
    assign h2_32 = sx16_32(cal_misc_reg[39:24]);
    assign h3    = cal_misc_reg[47:40];
    assign h4_32 = sx16_32(cal_hum_reg[15:0]);
    assign h5_32 = sx16_32(cal_hum_reg[31:16]);
    assign h6_32 = sx8_32(cal_hum_reg[39:32]);

    // pipe advance: the whole pipe moves unless the output is held
    logic       adv;
    logic [6:0] po_vld_reg;
    logic [13:1] vs_reg;

    assign adv      = !po_vld_reg[6] || m_tready;
    assign s_tready = adv;

    logic [19:0] raw_t, raw_p;
    logic [15:0] raw_h;
    assign raw_t = s_tdata[19:0];
    assign raw_p = s_tdata[39:20];
    assign raw_h = s_tdata[55:40];

    // front stage registers
    logic [19:0]        adcp_pipe_reg [1:9];
    logic [15:0]        adch_pipe_reg [1:6];
    logic [23:0]        temp_pipe_reg [6:13];
    logic [31:0]        s1_adiff_reg, s1_d_reg;
    logic [31:0]        s2_amul_reg, s2_dd_reg;
    logic [31:0]        s3_a_reg, s3_bmul_reg;
    logic [31:0]        s4_fine_reg;
    logic [31:0]        s5_tcm_reg, s5_hv_reg;
    logic signed [32:0] s5_q1_reg;
    logic [63:0]        s6_sq_reg, s6_q1p5_reg, s6_q1p2_reg;
    logic [31:0]        s6_m1_reg, s6_m2_reg, s6_m3_reg;
    pp_t                s7_pp6_reg, s7_pp3_reg;
    logic [63:0]        s7_q1p5_reg, s7_q1p2_reg;
    logic [31:0]        s7_x_reg, s7_s2_reg, s7_s3_reg;
    logic [63:0]        s8_a_reg, s8_sq3_reg, s8_q1p5_reg, s8_q1p2_reg;
    logic [31:0]        s8_m4_reg, s8_x_reg;
    logic [63:0]        s9_q2_reg, s9_dp_reg;
    logic [31:0]        s9_m5_reg, s9_x_reg;
    pp_t                s10_ppe_reg;
    logic [63:0]        s10_nb_reg;
    logic [31:0]        s10_y_reg, s10_x_reg;
    pp_t                s11_ppn_reg;
    logic [30:0]        s11_mb_reg;
    logic               s11_eneg_reg, s11_inv_reg;
    logic [31:0]        s11_hvv_reg;
    logic [63:0]        s12_n_reg;
    logic [30:0]        s12_mb_reg;
    logic               s12_eneg_reg, s12_inv_reg;
    logic [31:0]        s12_m7_reg, s12_hvv_reg;
    logic [63:0]        s13_ma_reg;
    logic [30:0]        s13_mb_reg;
    logic               s13_neg_reg, s13_inv_reg;
    logic [31:0]        s13_m8_reg, s13_hvv_reg;

    // combinational helpers for the front stages
    logic [31:0]        tc;
    logic signed [32:0] tsum;
    logic [23:0]        temp_sat;
    logic signed [65:0] sq_full;
    logic signed [63:0] q1p5_full, q1p2_full;
    logic [31:0]        hx_sum;
    logic [20:0]        p0_21;
    logic [63:0]        efull;
    logic [30:0]        e31;
    logic [31:0]        w15;

    always_comb begin
        // temperature with offset, saturated to 24 bits
        tc   = asr32(s5_tcm_reg, 8);
        tsum = $signed({tc[31], tc}) + $signed({{17{toff_reg[15]}}, toff_reg});
        if (tsum > 33'sd8388607) begin
            temp_sat = 24'h7FFFFF;
        end else if (tsum < -33'sd8388608) begin
            temp_sat = 24'h800000;
        end else begin
            temp_sat = tsum[23:0];
        end
        sq_full   = s5_q1_reg * s5_q1_reg;
        q1p5_full = s5_q1_reg * p5;
        q1p2_full = s5_q1_reg * p2;
        hx_sum    = {2'b0, adch_pipe_reg[6], 14'b0} - {h4_32[11:0], 20'b0}
                    - s6_m1_reg + 32'd16384;
        p0_21     = 21'd1048576 - {1'b0, adcp_pipe_reg[9]};
        efull     = pp_sum(s10_ppe_reg);
        e31       = efull[63:33];
        w15       = asr32(s11_hvv_reg, 15);
    end

    // front valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg <= '0;
        end else if (adv) begin
            vs_reg <= {vs_reg[12:1], s_tvalid};
        end
    end

    // front datapath: fine temperature, then pressure and humidity in parallel
    always_ff @(posedge aclk) begin
        if (adv) begin
            adcp_pipe_reg[1] <= raw_p;
            for (int k = 2; k <= 9; k++) adcp_pipe_reg[k] <= adcp_pipe_reg[k-1];
            adch_pipe_reg[1] <= raw_h;
            for (int k = 2; k <= 6; k++) adch_pipe_reg[k] <= adch_pipe_reg[k-1];
            temp_pipe_reg[6] <= temp_sat;
            for (int k = 7; k <= 13; k++) temp_pipe_reg[k] <= temp_pipe_reg[k-1];

            // stage 1
            s1_adiff_reg <= {15'b0, raw_t[19:3]} - {15'b0, t1, 1'b0};
            s1_d_reg     <= {16'b0, raw_t[19:4]} - {16'b0, t1};
            // stage 2
            s2_amul_reg  <= mul32lo(s1_adiff_reg, t2_32);
            s2_dd_reg    <= mul32lo(s1_d_reg, s1_d_reg);
            // stage 3
            s3_a_reg     <= asr32(s2_amul_reg, 11);
            s3_bmul_reg  <= mul32lo(asr32(s2_dd_reg, 12), t3_32);
            // stage 4: fine temperature
            s4_fine_reg  <= s3_a_reg + asr32(s3_bmul_reg, 14);
            // stage 5
            s5_tcm_reg   <= {s4_fine_reg[29:0], 2'b0} + s4_fine_reg + 32'd128;
            s5_q1_reg    <= $signed({s4_fine_reg[31], s4_fine_reg}) - 33'sd128000;
            s5_hv_reg    <= s4_fine_reg - 32'd76800;
            // stage 6
            s6_sq_reg    <= sq_full[63:0];
            s6_q1p5_reg  <= q1p5_full;
            s6_q1p2_reg  <= q1p2_full;
            s6_m1_reg    <= mul32lo(h5_32, s5_hv_reg);
            s6_m2_reg    <= mul32lo(s5_hv_reg, h6_32);
            s6_m3_reg    <= mul32lo(s5_hv_reg, {24'b0, h3});
            // stage 7
            s7_pp6_reg   <= mk_pp(s6_sq_reg, p6_64);
            s7_pp3_reg   <= mk_pp(s6_sq_reg, p3_64);
            s7_q1p5_reg  <= s6_q1p5_reg;
            s7_q1p2_reg  <= s6_q1p2_reg;
            s7_x_reg     <= asr32(hx_sum, 15);
            s7_s2_reg    <= asr32(s6_m2_reg, 10);
            s7_s3_reg    <= asr32(s6_m3_reg, 11) + 32'd32768;
            // stage 8
            s8_a_reg     <= pp_sum(s7_pp6_reg);
            s8_sq3_reg   <= pp_sum(s7_pp3_reg);
            s8_q1p5_reg  <= s7_q1p5_reg;
            s8_q1p2_reg  <= s7_q1p2_reg;
            s8_m4_reg    <= mul32lo(s7_s2_reg, s7_s3_reg);
            s8_x_reg     <= s7_x_reg;
            // stage 9
            s9_q2_reg    <= s8_a_reg + {s8_q1p5_reg[46:0], 17'b0} + {p4_64[28:0], 35'b0};
            s9_dp_reg    <= 64'h0000_8000_0000_0000 + asr64(s8_sq3_reg, 8)
                            + {s8_q1p2_reg[51:0], 12'b0};
            s9_m5_reg    <= mul32lo(asr32(s8_m4_reg, 10) + 32'd2097152, h2_32);
            s9_x_reg     <= s8_x_reg;
            // stage 10
            s10_ppe_reg  <= mk_pp(s9_dp_reg, {48'b0, p1});
            s10_nb_reg   <= {12'b0, p0_21, 31'b0} - s9_q2_reg;
            s10_y_reg    <= asr32(s9_m5_reg + 32'd8192, 14);
            s10_x_reg    <= s9_x_reg;
            // stage 11: divisor
            s11_inv_reg  <= (e31 == 31'd0);
            s11_eneg_reg <= e31[30];
            s11_mb_reg   <= e31[30] ? (31'd0 - e31) : e31;
            s11_ppn_reg  <= mk_pp(s10_nb_reg, 64'd3125);
            s11_hvv_reg  <= mul32lo(s10_x_reg, s10_y_reg);
            // stage 12: dividend
            s12_n_reg    <= pp_sum(s11_ppn_reg);
            s12_mb_reg   <= s11_mb_reg;
            s12_eneg_reg <= s11_eneg_reg;
            s12_inv_reg  <= s11_inv_reg;
            s12_m7_reg   <= mul32lo(w15, w15);
            s12_hvv_reg  <= s11_hvv_reg;
            // stage 13: magnitudes for the divider
            s13_ma_reg   <= s12_n_reg[63] ? (64'd0 - s12_n_reg) : s12_n_reg;
            s13_neg_reg  <= s12_n_reg[63] ^ s12_eneg_reg;
            s13_mb_reg   <= s12_mb_reg;
            s13_inv_reg  <= s12_inv_reg;
            s13_m8_reg   <= mul32lo(asr32(s12_m7_reg, 7), {24'b0, h1});
            s13_hvv_reg  <= s12_hvv_reg;
        end
    end

    // humidity finish and clamp, handed to the divider as sideband
    logic [31:0] hres, hclamp;
    div_in_t     din;
    div_out_t    dout;

    always_comb begin
        hres = s13_hvv_reg - asr32(s13_m8_reg, 4);
        if (hres[31]) begin
            hclamp = '0;
        end else if (hres > HUM_MAX) begin
            hclamp = HUM_MAX;
        end else begin
            hclamp = hres;
        end
        din.valid      = vs_reg[13];
        din.num        = s13_ma_reg;
        din.den        = s13_mb_reg;
        din.neg        = s13_neg_reg;
        din.side.temp  = temp_pipe_reg[13];
        din.side.humid = hclamp[28:12];
        din.side.inv   = s13_inv_reg;
    end

    esc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .din     (din),
        .dout    (dout)
    );

    // back stage registers
    side_t       po_side_reg [0:6];
    logic [63:0] po0_p_reg;
    logic [63:0] po1_p_reg, po1_r_reg;
    pp_t         po1_pp9_reg, po1_pp8_reg;
    logic [63:0] po2_p_reg, po2_r_reg, po2_m1_reg, po2_q2_reg;
    pp_t         po3_ppm_reg;
    logic [63:0] po3_p_reg, po3_q2_reg;
    logic [63:0] po4_p_reg, po4_q1_reg, po4_q2_reg;
    logic [63:0] po5_s_reg;
    logic [31:0] out_press_reg;
    logic [63:0] rsh, pf;
    logic [31:0] press_sat;

    always_comb begin
        rsh = asr64(po0_p_reg, 13);
        pf  = asr64(po5_s_reg, 8) + {p7_64[59:0], 4'b0};
        if (po_side_reg[5].inv || pf[63]) begin
            press_sat = '0;
        end else if (pf[63:32] != 32'd0) begin
            press_sat = 32'hFFFF_FFFF;
        end else begin
            press_sat = pf[31:0];
        end
    end

    // back valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            po_vld_reg <= '0;
        end else if (adv) begin
            po_vld_reg <= {po_vld_reg[5:0], dout.valid};
        end
    end

    // back datapath: sign, correction terms, final sum and saturation
    always_ff @(posedge aclk) begin
        if (adv) begin
            po_side_reg[0] <= dout.side;
            for (int k = 1; k <= 6; k++) po_side_reg[k] <= po_side_reg[k-1];
            po0_p_reg   <= dout.neg ? (64'd0 - dout.quo) : dout.quo;
            po1_p_reg   <= po0_p_reg;
            po1_r_reg   <= rsh;
            po1_pp9_reg <= mk_pp(rsh, p9_64);
            po1_pp8_reg <= mk_pp(po0_p_reg, p8_64);
            po2_p_reg   <= po1_p_reg;
            po2_r_reg   <= po1_r_reg;
            po2_m1_reg  <= pp_sum(po1_pp9_reg);
            po2_q2_reg  <= asr64(pp_sum(po1_pp8_reg), 19);
            po3_ppm_reg <= mk_pp(po2_m1_reg, po2_r_reg);
            po3_p_reg   <= po2_p_reg;
            po3_q2_reg  <= po2_q2_reg;
            po4_q1_reg  <= asr64(pp_sum(po3_ppm_reg), 25);
            po4_p_reg   <= po3_p_reg;
            po4_q2_reg  <= po3_q2_reg;
            po5_s_reg   <= po4_p_reg + po4_q1_reg + po4_q2_reg;
            out_press_reg <= press_sat;
        end
    end

    assign m_tvalid = po_vld_reg[6];
    assign m_tuser  = po_side_reg[6].inv;
    assign m_tdata  = {7'b0, po_side_reg[6].humid, out_press_reg, po_side_reg[6].temp};

endmodule

`default_nettype wire

// File: rtl/esc_checker.sv
`default_nettype none

`include "env_sensor_compensation_macros.svh"

// Port-level checks on the compensation block
module esc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic [esc_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                           m_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready
);
    // held result keeps its payload
    `ESC_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    // humidity never above 100 %
    `ESC_ASSERT(a_hum_range, m_tvalid |-> m_tdata[72:56] <= 17'd102400, "humidity above full scale")
    // invalid divisor forces pressure to zero
    `ESC_ASSERT(a_inv_zero, m_tvalid && m_tuser |-> m_tdata[55:24] == 32'd0, "pressure not zero on invalid")
    // reset empties the pipe
    `ESC_ASSERT_ALWAYS(a_rst_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (.*);

`default_nettype wire
